### src/knob_turn_event_qualifier_unit_macros.svh
// Assertion macros used by the knob turn event qualifier top level.
`ifndef KNOB_TURN_EVENT_QUALIFIER_UNIT_MACROS_SVH
`define KNOB_TURN_EVENT_QUALIFIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KTEQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KTEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/kteq_pkg.sv
// Types, constants and reset values of the knob turn event qualifier.
`default_nettype none

package kteq_pkg;

    // Field widths.
    localparam int REQ_W   = 2;
    localparam int MS_W    = 16;
    localparam int DELTA_W = 11;
    localparam int IDX_W   = 3;
    localparam int THR_W   = 8;
    localparam int RATE_W  = 16;
    localparam int CODE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // The tick accumulator never holds more than the threshold plus one delta.
    localparam int TICK_W = 16;
    localparam int MAG_W  = 11;

    // Ticks per second compared as ticks * 1000 against rate * milliseconds.
    localparam int MS_SCALE = 1000;
    localparam int LHS_W    = MAG_W + 10;
    localparam int CLAMP_W  = LHS_W + 1;
    localparam int RHS_W    = RATE_W + CLAMP_W;

    localparam int TIME_ACC_WIDTH_DEF = 32;

    // Register reset values.
    localparam logic [THR_W-1:0]  TICK_THR_RST   = THR_W'(5);
    localparam logic [RATE_W-1:0] FAST_RATE_RST  = RATE_W'(150);
    localparam logic [IDX_W-1:0]  REWARD_IDX_RST = IDX_W'(0);
    localparam logic [IDX_W-1:0]  FLUSH_IDX_RST  = IDX_W'(7);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_THR   = 2'd0,
        CFG_FAST_RATE  = 2'd1,
        CFG_REWARD_IDX = 2'd2,
        CFG_FLUSH_IDX  = 2'd3
    } t_cfg_idx;

    // Request types.
    typedef enum logic [REQ_W-1:0] {
        REQ_POSITION = 2'd0,
        REQ_BUTTON   = 2'd1,
        REQ_INPUT    = 2'd2,
        REQ_ACK      = 2'd3
    } t_req_type;

    // Event codes.
    typedef enum logic [CODE_W-1:0] {
        EV_LEFT       = 3'd0,
        EV_LEFT_FAST  = 3'd1,
        EV_RIGHT      = 3'd2,
        EV_RIGHT_FAST = 3'd3,
        EV_PUSH       = 3'd4,
        EV_REWARD     = 3'd5,
        EV_FLUSH      = 3'd6
    } t_event;

    typedef struct packed {
        logic [THR_W-1:0]  tick_thr;
        logic [RATE_W-1:0] fast_rate;
        logic [IDX_W-1:0]  reward_idx;
        logic [IDX_W-1:0]  flush_idx;
    } t_cfg;

    // Knob state apart from the elapsed-time accumulator.
    typedef struct packed {
        logic signed [DELTA_W-1:0] last_delta;
        logic signed [TICK_W-1:0]  tick_accum;
        logic                      button_level;
        logic                      turn_pending;
    } t_knob_state;

    typedef struct packed {
        logic   valid;
        t_event code;
    } t_result;

endpackage

`default_nettype wire

### src/kteq_step.sv
// Combinational next-state and event logic for one request.
`default_nettype none

module kteq_step import kteq_pkg::*; #(
    parameter int TIME_ACC_WIDTH = TIME_ACC_WIDTH_DEF
) (
    input  t_cfg                       i_cfg,
    input  t_req_type                  i_req_type,
    input  logic [MS_W-1:0]            i_elapsed_ms,
    input  logic signed [DELTA_W-1:0]  i_tick_delta,
    input  logic [IDX_W-1:0]           i_input_index,
    input  logic                       i_input_level,
    input  t_knob_state                i_state,
    input  logic [TIME_ACC_WIDTH-1:0]  i_time_accum,
    output t_knob_state                o_state,
    output logic [TIME_ACC_WIDTH-1:0]  o_time_accum,
    output t_result                    o_result
);

    logic                        last_pos, last_neg, delta_pos, delta_neg, reverse;
    logic signed [TICK_W-1:0]    delta_ext, tick_sum, tick_abs;
    logic [TIME_ACC_WIDTH:0]     time_wide;
    logic [TIME_ACC_WIDTH-1:0]   time_sum;
    logic [MAG_W-1:0]            mag;
    logic [CLAMP_W-1:0]          time_clamped;
    logic [LHS_W-1:0]            lhs;
    logic [RHS_W-1:0]            rhs;
    logic                        crossed, fast;

    // Direction reversal needs two nonzero deltas of opposite sign.
    assign last_pos  = !i_state.last_delta[DELTA_W-1] && (i_state.last_delta != '0);
    assign last_neg  = i_state.last_delta[DELTA_W-1];
    assign delta_pos = !i_tick_delta[DELTA_W-1] && (i_tick_delta != '0);
    assign delta_neg = i_tick_delta[DELTA_W-1];
    assign reverse   = (last_pos && delta_neg) || (last_neg && delta_pos);

    // Accumulate ticks and saturating elapsed time, or restart on reversal.
    assign delta_ext = {{(TICK_W-DELTA_W){i_tick_delta[DELTA_W-1]}}, i_tick_delta};
    assign tick_sum  = reverse ? delta_ext : i_state.tick_accum + delta_ext;
    assign time_wide = {1'b0, i_time_accum} + (TIME_ACC_WIDTH+1)'(i_elapsed_ms);
    assign time_sum  = reverse ? TIME_ACC_WIDTH'(i_elapsed_ms)
                     : (time_wide[TIME_ACC_WIDTH] ? '1 : time_wide[TIME_ACC_WIDTH-1:0]);

    // Magnitude stays below the threshold plus one delta, so it fits MAG_W bits.
    assign tick_abs = tick_sum[TICK_W-1] ? -tick_sum : tick_sum;
    assign mag      = tick_abs[MAG_W-1:0];
    assign crossed  = tick_abs > $signed({{(TICK_W-THR_W){1'b0}}, i_cfg.tick_thr});

    // Any time at or above the clamp point already beats the largest tick term,
    // so the time operand of the rate product can be clamped.
    generate
        if (TIME_ACC_WIDTH > CLAMP_W) begin : g_clamp
            assign time_clamped = (|time_sum[TIME_ACC_WIDTH-1:CLAMP_W-1])
                                ? {1'b1, {(CLAMP_W-1){1'b0}}}
                                : time_sum[CLAMP_W-1:0];
        end else begin : g_no_clamp
            assign time_clamped = CLAMP_W'(time_sum);
        end
    endgenerate

    // Fast turn when ticks * 1000 exceeds rate * milliseconds.
    assign lhs  = {{(LHS_W-MAG_W){1'b0}}, mag} * LHS_W'(MS_SCALE);
    assign rhs  = i_cfg.fast_rate * time_clamped;
    assign fast = RHS_W'(lhs) > rhs;

    // Request decode.
    always_comb begin
        o_state         = i_state;
        o_time_accum    = i_time_accum;
        o_result.valid  = 1'b0;
        o_result.code   = EV_LEFT;
        unique case (i_req_type)
            REQ_POSITION: begin
                o_state.last_delta = i_tick_delta;
                o_state.tick_accum = tick_sum;
                o_time_accum       = time_sum;
                if (crossed) begin
                    o_state.tick_accum   = '0;
                    o_time_accum         = '0;
                    o_state.turn_pending = 1'b1;
                    o_result.valid       = !i_state.turn_pending;
                    if (tick_sum[TICK_W-1]) begin
                        o_result.code = fast ? EV_RIGHT_FAST : EV_RIGHT;
                    end else begin
                        o_result.code = fast ? EV_LEFT_FAST : EV_LEFT;
                    end
                end
            end
            REQ_BUTTON: begin
                o_state.button_level = i_input_level;
                o_state.tick_accum   = '0;
                o_time_accum         = '0;
                o_result.valid       = !i_input_level && i_state.button_level;
                o_result.code        = EV_PUSH;
            end
            REQ_INPUT: begin
                if (i_input_level && (i_input_index == i_cfg.reward_idx)) begin
                    o_result.valid = 1'b1;
                    o_result.code  = EV_REWARD;
                end else if (i_input_level && (i_input_index == i_cfg.flush_idx)) begin
                    o_result.valid = 1'b1;
                    o_result.code  = EV_FLUSH;
                end
            end
            REQ_ACK: begin
                o_state.turn_pending = 1'b0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/knob_turn_event_qualifier_unit.sv
// Knob turn event qualifier: top level with request, result and config ports.
//
// Turns knob position, knob button and digital input requests into front-panel
// events. One request is taken per clock while the input side is not stalled;
// an event from a request shows on the result port once the result register
// loads it (the input register feeds the result register through one stage of
// logic). The whole update of a request, including the single 16 x 22 bit rate
// multiply, is done in the one stage between those registers. The input side
// stalls only while a result waits in the result register under downstream
// stall. Configuration writes are always ready and take effect at once; write
// them only while no request is in flight. No clearing pass after reset.
`default_nettype none
`include "knob_turn_event_qualifier_unit_macros.svh"

module knob_turn_event_qualifier_unit import kteq_pkg::*; #(
    parameter int TIME_ACC_WIDTH = TIME_ACC_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Request channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [REQ_W-1:0]           i_req_type,
    input  logic [MS_W-1:0]            i_elapsed_ms,
    input  logic signed [DELTA_W-1:0]  i_tick_delta,
    input  logic [IDX_W-1:0]           i_input_index,
    input  logic                       i_input_level,
    // Result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [CODE_W-1:0]          o_event_code,
    // Configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cfg                       r_cfg;
    logic                       r_in_valid;
    t_req_type                  r_req_type;
    logic [MS_W-1:0]            r_elapsed_ms;
    logic signed [DELTA_W-1:0]  r_tick_delta;
    logic [IDX_W-1:0]           r_input_index;
    logic                       r_input_level;
    t_knob_state                r_state;
    t_knob_state                n_state;
    logic [TIME_ACC_WIDTH-1:0]  r_time_accum;
    logic [TIME_ACC_WIDTH-1:0]  n_time_accum;
    t_result                    step_result;
    logic                       r_out_valid;
    t_event                     r_out_code;
    logic                       out_free;
    logic                       proc;
    logic                       accum_in_range;
    logic                       turn_reported;
    logic                       ack_taken;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_thr   <= TICK_THR_RST;
            r_cfg.fast_rate  <= FAST_RATE_RST;
            r_cfg.reward_idx <= REWARD_IDX_RST;
            r_cfg.flush_idx  <= FLUSH_IDX_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TICK_THR:   r_cfg.tick_thr   <= i_cfg_data[THR_W-1:0];
                CFG_FAST_RATE:  r_cfg.fast_rate  <= i_cfg_data[RATE_W-1:0];
                CFG_REWARD_IDX: r_cfg.reward_idx <= i_cfg_data[IDX_W-1:0];
                CFG_FLUSH_IDX:  r_cfg.flush_idx  <= i_cfg_data[IDX_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // The stage works whenever the result register is free to load.
    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req_type    <= t_req_type'(i_req_type);
            r_elapsed_ms  <= i_elapsed_ms;
            r_tick_delta  <= i_tick_delta;
            r_input_index <= i_input_index;
            r_input_level <= i_input_level;
        end
    end

    // Request evaluation.
    kteq_step #(
        .TIME_ACC_WIDTH (TIME_ACC_WIDTH)
    ) u_step (
        .i_cfg         (r_cfg),
        .i_req_type    (r_req_type),
        .i_elapsed_ms  (r_elapsed_ms),
        .i_tick_delta  (r_tick_delta),
        .i_input_index (r_input_index),
        .i_input_level (r_input_level),
        .i_state       (r_state),
        .i_time_accum  (r_time_accum),
        .o_state       (n_state),
        .o_time_accum  (n_time_accum),
        .o_result      (step_result)
    );

    // Knob state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_time_accum <= '0;
        end else if (proc) begin
            r_state      <= n_state;
            r_time_accum <= n_time_accum;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && step_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && step_result.valid) begin
            r_out_code <= step_result.code;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_code = r_out_code;

    // Conditions watched by the assertions below.
    assign accum_in_range = (r_state.tick_accum <= 16'sd255) && (r_state.tick_accum >= -16'sd255);
    assign turn_reported  = proc && step_result.valid &&
                            (step_result.code inside {EV_LEFT, EV_LEFT_FAST, EV_RIGHT,
                                                      EV_RIGHT_FAST});
    assign ack_taken      = proc && (r_req_type == REQ_ACK);

    // The tick accumulator is cleared whenever its magnitude passes the threshold.
    `KTEQ_ASSERT_SAME(a_accum_bound, i_clk, i_rst_n, 1'b1, accum_in_range, "tick accumulator out of range")

    // A reported turn leaves the pending flag set.
    `KTEQ_ASSERT_NEXT(a_turn_sets_pending, i_clk, i_rst_n, turn_reported, r_state.turn_pending, "turn event without pending flag")

    // An acknowledge clears the pending flag and reports nothing.
    `KTEQ_ASSERT_NEXT(a_ack_clears, i_clk, i_rst_n, ack_taken, !r_state.turn_pending && !r_out_valid, "acknowledge did not clear pending flag")

endmodule

`default_nettype wire
